// ===== design/lcr_pkg.sv =====
// shared types and constants for the line command receive ring
// no dependencies; imported by lcr_ctrl, the top level, the checker and the bench
`timescale 1ns / 1ps

package lcr_pkg;

    // item kinds carried on the input tuser
    localparam logic OP_RX    = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // special characters
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_FF = 8'hff;

    typedef enum logic [2:0] {
        STAT_STORED   = 3'd0,
        STAT_IGNORED  = 3'd1,
        STAT_CLOSED   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_TOO_LONG = 3'd4,
        STAT_NONE     = 3'd5,
        STAT_CHAR     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN_RD,
        ST_EMIT
    } state_t;

endpackage

// ===== design/lcr_ram.sv =====
// simple dual-port synchronous memory, one write and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module lcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lcr_ctrl.sv =====
// sequencer for the line ring: pointers, receive decode, fetch walk, output register
// depends on lcr_pkg; drives the line and slot-length memories
`timescale 1ns / 1ps

module lcr_ctrl
    import lcr_pkg::*;
#(
    parameter int LINE_BYTES = 64,
    parameter int LINE_SLOTS = 8
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [7:0]                                s_tdata,
    input  logic [0:0]                                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [15:0]                               m_tdata,
    output logic [2:0]                                m_tuser,
    output logic                                      m_tlast,
    output logic                                      line_we,
    output logic [$clog2(LINE_SLOTS*LINE_BYTES)-1:0] line_waddr,
    output logic [7:0]                                line_wdata,
    output logic                                      line_re,
    output logic [$clog2(LINE_SLOTS*LINE_BYTES)-1:0] line_raddr,
    input  logic [7:0]                                line_rdata,
    output logic                                      len_we,
    output logic [$clog2(LINE_SLOTS)-1:0]             len_waddr,
    output logic [$clog2(LINE_BYTES)-1:0]             len_wdata,
    output logic                                      len_re,
    output logic [$clog2(LINE_SLOTS)-1:0]             len_raddr,
    input  logic [$clog2(LINE_BYTES)-1:0]             len_rdata
);

    localparam int SLOT_W = $clog2(LINE_SLOTS);
    localparam int LEN_W  = $clog2(LINE_BYTES);
    localparam int ADDR_W = $clog2(LINE_SLOTS * LINE_BYTES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(LINE_SLOTS - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(LINE_BYTES - 1);
    localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(LINE_BYTES);

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  char_pos_reg, char_pos_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [5:0]        out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic [SLOT_W-1:0] wr_slot_inc;
    logic [SLOT_W-1:0] rd_slot_inc;
    logic              ring_full;
    logic              emit_last;

    function automatic logic [ADDR_W-1:0] line_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [LEN_W-1:0] pos);
        line_addr = ADDR_W'(slot) * SLOT_SPAN + ADDR_W'(pos);
    endfunction

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE) && out_free;
    assign accept      = s_tvalid && s_tready;
    assign wr_slot_inc = (wr_slot_reg == LAST_SLOT) ? '0 : wr_slot_reg + 1'b1;
    assign rd_slot_inc = (rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + 1'b1;
    assign ring_full   = (wr_slot_inc == rd_slot_reg);
    assign emit_last   = (idx_reg == len_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            char_pos_reg  <= '0;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            char_pos_reg  <= char_pos_next;
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_char_reg   <= out_char_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        char_pos_next   = char_pos_reg;
        wr_slot_next    = wr_slot_reg;
        rd_slot_next    = rd_slot_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_char_next   = out_char_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        line_we         = 1'b0;
        line_waddr      = line_addr(wr_slot_reg, char_pos_reg);
        line_wdata      = s_tdata;
        line_re         = 1'b0;
        line_raddr      = line_addr(rd_slot_reg, '0);
        len_we          = 1'b0;
        len_waddr       = wr_slot_reg;
        len_wdata       = char_pos_reg;
        len_re          = 1'b0;
        len_raddr       = rd_slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == OP_RX)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = '0;
                        out_len_next   = '0;
                        out_last_next  = 1'b1;
                        if (s_tdata == CHAR_CR || s_tdata == CHAR_FF)
                        begin
                            out_status_next = STAT_IGNORED;
                        end
                        else if (s_tdata == CHAR_LF)
                        begin
                            if (ring_full)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                len_we          = 1'b1;
                                char_pos_next   = '0;
                                wr_slot_next    = wr_slot_inc;
                                out_status_next = STAT_CLOSED;
                            end
                        end
                        else if (char_pos_reg < MAX_LEN)
                        begin
                            line_we         = 1'b1;
                            char_pos_next   = char_pos_reg + 1'b1;
                            out_status_next = STAT_STORED;
                        end
                        else
                        begin
                            out_status_next = STAT_TOO_LONG;
                        end
                    end
                    else if (rd_slot_reg == wr_slot_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_NONE;
                        out_char_next   = '0;
                        out_len_next    = '0;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        len_re     = 1'b1;
                        state_next = ST_LEN_RD;
                    end
                end
            end

            ST_LEN_RD:
            begin
                if (len_rdata == '0)
                begin
                    // empty line: single closed result, slot consumed
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_CLOSED;
                        out_char_next   = '0;
                        out_len_next    = '0;
                        out_last_next   = 1'b1;
                        rd_slot_next    = rd_slot_inc;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    len_next   = len_rdata;
                    idx_next   = '0;
                    line_re    = 1'b1;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // line_rdata holds the character at idx_reg until the next read
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_CHAR;
                    out_char_next   = line_rdata;
                    out_len_next    = 6'(len_reg);
                    out_last_next   = emit_last;
                    if (emit_last)
                    begin
                        rd_slot_next = rd_slot_inc;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        line_re    = 1'b1;
                        line_raddr = line_addr(rd_slot_reg, idx_reg + 1'b1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_len_reg, out_char_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/line_command_receive_ring_top.sv =====
// a receive word's result is registered and appears in the cycle after acceptance; a fetch
// reads the slot length, then the line memory, before its first character is registered
// throughput, unless the output stalls: one receive word per cycle; a fetch holds input
// to the end of its line, one character per cycle paced by each memory's single read port
// reset: asynchronous, clears pointers, open-line position and output valid; the memories
// are not cleared and only entries written since reset are read
`timescale 1ns / 1ps

module line_command_receive_ring_top
    import lcr_pkg::*;
#(
    parameter int LINE_BYTES = 64,
    parameter int LINE_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // line_char[7:0], line_length[13:8], zero[15:14]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    localparam int SLOT_W = $clog2(LINE_SLOTS);
    localparam int LEN_W  = $clog2(LINE_BYTES);
    localparam int ADDR_W = $clog2(LINE_SLOTS * LINE_BYTES);

    logic              line_we;
    logic [ADDR_W-1:0] line_waddr;
    logic [7:0]        line_wdata;
    logic              line_re;
    logic [ADDR_W-1:0] line_raddr;
    logic [7:0]        line_rdata;
    logic              len_we;
    logic [SLOT_W-1:0] len_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic              len_re;
    logic [SLOT_W-1:0] len_raddr;
    logic [LEN_W-1:0]  len_rdata;

    lcr_ctrl #(
        .LINE_BYTES (LINE_BYTES),
        .LINE_SLOTS (LINE_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .line_we    (line_we),
        .line_waddr (line_waddr),
        .line_wdata (line_wdata),
        .line_re    (line_re),
        .line_raddr (line_raddr),
        .line_rdata (line_rdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_re     (len_re),
        .len_raddr  (len_raddr),
        .len_rdata  (len_rdata)
    );

    lcr_ram #(
        .WIDTH (8),
        .DEPTH (LINE_SLOTS * LINE_BYTES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    lcr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (LINE_SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

endmodule

// ===== design/lcr_checker.sv =====
// port-level checks for the line command receive ring, bound to the top level
// depends on lcr_pkg for the status codes
`timescale 1ns / 1ps

module lcr_checker
    import lcr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // only line characters come in runs
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_CHAR |-> m_tlast)
        else $error("non-character result without last");

    // character field is zero outside line characters
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_CHAR |-> m_tdata[7:0] == 8'h00)
        else $error("character field set on non-character result");

    // length only on fetched characters
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_CHAR |-> m_tdata[15:8] == 8'h00)
        else $error("length field set on non-character result");

    // no input taken while a fetched line is still being walked
    a_fetch_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_CHAR && !m_tlast |-> !s_tready)
        else $error("input accepted during a line fetch");

endmodule

bind line_command_receive_ring_top lcr_checker u_lcr_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking bench for line_command_receive_ring_top: drives receive and fetch words,
// predicts every result word with a line ring tracker and checks it on the output stream
// depends on lcr_pkg and the line_command_receive_ring_top rtl
`timescale 1ns / 1ps

module tb_top;
    import lcr_pkg::*;

    localparam int LINE_BYTES  = 64;
    localparam int LINE_SLOTS  = 8;
    localparam int ITEMS       = 480;
    localparam int CALM_ITEMS  = 80;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        logic [2:0] status;
        logic [7:0] ch;
        logic [5:0] len;
        logic       last;
    } line_result_t;

    class line_ring_tracker;
        logic [7:0]   line_mem [LINE_SLOTS][LINE_BYTES];
        logic [5:0]   line_len [LINE_SLOTS];
        int unsigned  open_pos = 0;
        int unsigned  wr_slot  = 0;
        int unsigned  rd_slot  = 0;
        line_result_t due_results[$];
        int           mismatches = 0;
        int           checked    = 0;
        int           status_count[7];

        function void push(input status_t st, input logic [7:0] ch, input logic [5:0] len,
                           input logic last);
            line_result_t r;
            r.status = st;
            r.ch     = ch;
            r.len    = len;
            r.last   = last;
            due_results.push_back(r);
            status_count[st]++;
        endfunction

        // prediction for one accepted input word
        function void note_word(input logic op, input logic [7:0] b);
            int unsigned slot;
            int unsigned n;
            if (op == OP_RX)
            begin
                if (b == CHAR_CR || b == CHAR_FF)
                    push(STAT_IGNORED, 8'h00, 6'd0, 1'b1);
                else if (b == CHAR_LF)
                begin
                    if ((wr_slot + 1) % LINE_SLOTS == rd_slot)
                        push(STAT_FULL, 8'h00, 6'd0, 1'b1);  // open line stays open
                    else
                    begin
                        line_len[wr_slot] = open_pos[5:0];
                        open_pos = 0;
                        wr_slot  = (wr_slot + 1) % LINE_SLOTS;
                        push(STAT_CLOSED, 8'h00, 6'd0, 1'b1);
                    end
                end
                else if (open_pos < LINE_BYTES - 1)
                begin
                    line_mem[wr_slot][open_pos] = b;
                    open_pos++;
                    push(STAT_STORED, 8'h00, 6'd0, 1'b1);
                end
                else
                    push(STAT_TOO_LONG, 8'h00, 6'd0, 1'b1);
            end
            else if (rd_slot == wr_slot)
                push(STAT_NONE, 8'h00, 6'd0, 1'b1);
            else
            begin
                slot    = rd_slot;
                n       = 32'(line_len[slot]);
                rd_slot = (rd_slot + 1) % LINE_SLOTS;
                // an empty line is consumed with a single closed status
                if (n == 0)
                    push(STAT_CLOSED, 8'h00, 6'd0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        push(STAT_CHAR, line_mem[slot][i], n[5:0], (i == n - 1));
            end
        endfunction

        function void check_result(input logic [2:0] st, input logic [15:0] data,
                                   input logic last);
            line_result_t want;
            checked++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d char %02h len %0d last %0b",
                             st, data[7:0], data[13:8], last);
                return;
            end
            want = due_results.pop_front();
            if (st !== want.status || data[7:0] !== want.ch || data[13:8] !== want.len ||
                data[15:14] !== 2'b00 || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected status %0d char %02h len %0d last %0b, %s",
                             $realtime, want.status, want.ch, want.len, want.last,
                             $sformatf("got status %0d char %02h len %0d pad %0b last %0b",
                                       st, data[7:0], data[13:8], data[15:14], last));
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    line_ring_tracker sb;
    int words_sent = 0;
    bit calm       = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    int idle_count = 0;

    line_command_receive_ring_top #(
        .LINE_BYTES (LINE_BYTES),
        .LINE_SLOTS (LINE_SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_word(input logic op, input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            gap = int'($urandom_range(1, 3));
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_word(op, b);
        words_sent++;
    endtask

    task automatic send_line(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_LF)
                b = 8'h41;
            if ($urandom_range(0, 9) == 0)
                b = $urandom_range(0, 1) ? CHAR_CR : CHAR_FF;
            send_word(OP_RX, b);
        end
        send_word(OP_RX, CHAR_LF);
    endtask

    task automatic run_directed();
        send_word(OP_FETCH, 8'hff);      // nothing waiting yet
        send_word(OP_RX, CHAR_CR);
        send_word(OP_RX, CHAR_FF);
        send_word(OP_RX, 8'h00);
        send_word(OP_RX, 8'h7f);
        send_word(OP_RX, 8'h80);
        send_word(OP_RX, CHAR_LF);
        send_word(OP_RX, CHAR_LF);       // empty line
        send_word(OP_FETCH, 8'h00);
        send_word(OP_FETCH, CHAR_LF);
        send_word(OP_FETCH, 8'h55);
        // fill the ring, the eighth line feed overflows
        repeat (LINE_SLOTS) send_word(OP_RX, CHAR_LF);
        send_word(OP_RX, 8'h41);
        send_word(OP_RX, CHAR_LF);
        send_word(OP_FETCH, 8'haa);
        send_word(OP_RX, CHAR_LF);
    endtask

    task automatic run_random();
        int kind;
        int n;
        bit first_seq;
        first_seq = 1'b1;
        while (words_sent < ITEMS)
        begin
            if (!hold_done && words_sent >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (words_sent >= ITEMS - CALM_ITEMS)
                calm = 1'b1;
            kind = int'($urandom_range(0, 9));
            if (first_seq)
            begin
                send_line(LINE_BYTES + 2);   // overlong line at least once
                first_seq = 1'b0;
            end
            else if (kind <= 5)
                send_line(($urandom_range(0, 15) == 0) ? int'($urandom_range(60, 70))
                                                       : int'($urandom_range(0, 10)));
            else if (kind <= 7)
            begin
                n = int'($urandom_range(1, 3));
                repeat (n) send_word(OP_FETCH, 8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                n = int'($urandom_range(1, 6));
                repeat (n) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                n = int'($urandom_range(1, LINE_SLOTS + 1));
                repeat (n) send_word(OP_RX, CHAR_LF);
            end
        end
    endtask

    // receiver: short random stalls, one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = int'($urandom_range(1, 3)) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else if (idle_count >= IDLE_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

    initial
    begin : stimulus
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d input words, %0d result words checked, %0d mismatches",
                 words_sent, sb.checked, sb.mismatches);
        $display("closed %0d, ring full %0d, too long %0d, none waiting %0d, chars %0d",
                 sb.status_count[STAT_CLOSED], sb.status_count[STAT_FULL],
                 sb.status_count[STAT_TOO_LONG], sb.status_count[STAT_NONE],
                 sb.status_count[STAT_CHAR]);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
